>>> rtl/kvp_pkg.sv
`timescale 1ns / 1ps

package kvp_pkg;

	localparam int KEY_BYTES_DEF   = 64;
	localparam int VALUE_BYTES_DEF = 256;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_G   = 8'h47;
	localparam logic [7:0] CH_E   = 8'h45;
	localparam logic [7:0] CH_T   = 8'h54;
	localparam logic [7:0] CH_D   = 8'h44;
	localparam logic [7:0] CH_L   = 8'h4C;
	localparam logic [7:0] CH_S   = 8'h53;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_CMD,
		PH_GAP,
		PH_KEY,
		PH_TRAIL,
		PH_VALUE,
		PH_DISCARD
	} kvp_phase_t;

	typedef enum logic [1:0] {
		CMD_GET,
		CMD_SET,
		CMD_DEL
	} kvp_cmd_t;

	typedef enum logic [1:0] {
		PART_KEY,
		PART_VALUE,
		PART_VERDICT
	} kvp_part_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_end;
	} kvp_in_t;

	typedef struct packed {
		logic [1:0] part;
		logic [7:0] out_byte;
		logic [1:0] command;
		logic       accepted;
		logic [5:0] key_length;
		logic [7:0] value_length;
	} kvp_res_t;

	typedef struct packed {
		logic [1:0] num;
		kvp_res_t   first;
		kvp_res_t   second;
	} kvp_push_t;

endpackage

>>> rtl/kvp_parser.sv
`timescale 1ns / 1ps

module kvp_parser #(
	parameter int KEY_BYTES   = kvp_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = kvp_pkg::VALUE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  kvp_pkg::kvp_in_t   item,
	output kvp_pkg::kvp_push_t push
);

	localparam int KW  = $clog2(KEY_BYTES);
	localparam int VW  = $clog2(VALUE_BYTES);
	localparam int KLW = (KW > 6) ? KW : 6;
	localparam int VLW = (VW > 8) ? VW : 8;

	kvp_pkg::kvp_phase_t phase_q, phase_d;
	kvp_pkg::kvp_cmd_t   kind_q, kind_d;
	logic [1:0]          chars_q, chars_d;
	logic [KW-1:0]       kcnt_q, kcnt_d;
	logic [VW-1:0]       vcnt_q, vcnt_d;
	logic                err_q, err_d;

	logic [7:0]       c;
	logic             last;
	logic             blank;
	logic             do_letter;
	logic [1:0]       pos;
	logic             do_key;
	logic             do_val;
	logic             byte_v;
	kvp_pkg::kvp_res_t byte_r;
	kvp_pkg::kvp_res_t verd_r;
	logic             ok;
	logic [KLW-1:0]   klen_x;
	logic [VLW-1:0]   vlen_x;

	assign c     = item.in_byte;
	assign last  = item.line_end;
	assign blank = (c == kvp_pkg::CH_SP) || (c == kvp_pkg::CH_TAB);

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		chars_d   = chars_q;
		kcnt_d    = kcnt_q;
		vcnt_d    = vcnt_q;
		err_d     = err_q;
		do_letter = 1'b0;
		pos       = chars_q;
		do_key    = 1'b0;
		do_val    = 1'b0;
		byte_v    = 1'b0;
		byte_r    = '0;

		if (!(last && c == kvp_pkg::CH_CR)) begin
			case (phase_q)
				kvp_pkg::PH_LEAD: begin
					if (!blank) begin
						phase_d   = kvp_pkg::PH_CMD;
						do_letter = 1'b1;
						pos       = 2'd0;
					end
				end
				kvp_pkg::PH_CMD: begin
					if (chars_q != 2'd3) begin
						do_letter = 1'b1;
					end else if (c == kvp_pkg::CH_SP) begin
						phase_d = kvp_pkg::PH_GAP;
					end else begin
						err_d   = 1'b1;
						phase_d = kvp_pkg::PH_DISCARD;
					end
				end
				kvp_pkg::PH_GAP: begin
					if (!blank) begin
						phase_d = kvp_pkg::PH_KEY;
						do_key  = 1'b1;
					end
				end
				kvp_pkg::PH_KEY: begin
					if (c == kvp_pkg::CH_SP) begin
						phase_d = kvp_pkg::PH_TRAIL;
					end else begin
						do_key = 1'b1;
					end
				end
				kvp_pkg::PH_TRAIL: begin
					if (!blank) begin
						if (kind_q != kvp_pkg::CMD_SET) begin
							err_d   = 1'b1;
							phase_d = kvp_pkg::PH_DISCARD;
						end else begin
							phase_d = kvp_pkg::PH_VALUE;
							do_val  = 1'b1;
						end
					end
				end
				kvp_pkg::PH_VALUE: begin
					do_val = 1'b1;
				end
				default: begin
				end
			endcase
		end

		if (do_letter) begin
			case (pos)
				2'd0: begin
					chars_d = 2'd1;
					if (c == kvp_pkg::CH_G) begin
						kind_d = kvp_pkg::CMD_GET;
					end else if (c == kvp_pkg::CH_S) begin
						kind_d = kvp_pkg::CMD_SET;
					end else if (c == kvp_pkg::CH_D) begin
						kind_d = kvp_pkg::CMD_DEL;
					end else begin
						chars_d = chars_q;
						err_d   = 1'b1;
						phase_d = kvp_pkg::PH_DISCARD;
					end
				end
				2'd1: begin
					if (c == kvp_pkg::CH_E) begin
						chars_d = 2'd2;
					end else begin
						err_d   = 1'b1;
						phase_d = kvp_pkg::PH_DISCARD;
					end
				end
				default: begin
					if (c == ((kind_q == kvp_pkg::CMD_DEL) ? kvp_pkg::CH_L : kvp_pkg::CH_T)) begin
						chars_d = 2'd3;
					end else begin
						err_d   = 1'b1;
						phase_d = kvp_pkg::PH_DISCARD;
					end
				end
			endcase
		end

		if (do_key) begin
			if (kcnt_q == KW'(KEY_BYTES - 1)) begin
				err_d   = 1'b1;
				phase_d = kvp_pkg::PH_DISCARD;
			end else begin
				kcnt_d      = kcnt_q + KW'(1);
				byte_v      = 1'b1;
				byte_r.part = kvp_pkg::PART_KEY;
			end
		end

		if (do_val) begin
			if (vcnt_q == VW'(VALUE_BYTES - 1)) begin
				err_d   = 1'b1;
				phase_d = kvp_pkg::PH_DISCARD;
			end else begin
				vcnt_d      = vcnt_q + VW'(1);
				byte_v      = 1'b1;
				byte_r.part = kvp_pkg::PART_VALUE;
			end
		end
		byte_r.out_byte = byte_v ? c : 8'd0;

		// verdict sees the state after this byte
		ok = 1'b0;
		if (!err_d) begin
			if (phase_d == kvp_pkg::PH_KEY || phase_d == kvp_pkg::PH_TRAIL) begin
				ok = (kind_d != kvp_pkg::CMD_SET);
			end else if (phase_d == kvp_pkg::PH_VALUE) begin
				ok = (kind_d == kvp_pkg::CMD_SET);
			end
		end
		klen_x = KLW'(kcnt_d);
		vlen_x = VLW'(vcnt_d);
		verd_r = '0;
		verd_r.part = kvp_pkg::PART_VERDICT;
		if (ok) begin
			verd_r.command    = kind_d;
			verd_r.accepted   = 1'b1;
			verd_r.key_length = klen_x[5:0];
			if (kind_d == kvp_pkg::CMD_SET) begin
				verd_r.value_length = vlen_x[7:0];
			end
		end

		push.num    = {1'b0, byte_v} + {1'b0, last};
		push.first  = byte_v ? byte_r : verd_r;
		push.second = verd_r;
		if (!take) begin
			push.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kvp_pkg::PH_LEAD;
			kind_q  <= kvp_pkg::CMD_GET;
			chars_q <= '0;
			kcnt_q  <= '0;
			vcnt_q  <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			if (last) begin
				phase_q <= kvp_pkg::PH_LEAD;
				kind_q  <= kvp_pkg::CMD_GET;
				chars_q <= '0;
				kcnt_q  <= '0;
				vcnt_q  <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				kind_q  <= kind_d;
				chars_q <= chars_d;
				kcnt_q  <= kcnt_d;
				vcnt_q  <= vcnt_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

>>> rtl/kvp_queue.sv
`timescale 1ns / 1ps

module kvp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  kvp_pkg::kvp_push_t push,
	output logic               full,
	output logic               res_valid,
	input  logic               res_stall,
	output kvp_pkg::kvp_res_t  res_item
);

	localparam int AW = $clog2(kvp_pkg::QUEUE_DEPTH);
	localparam int CW = AW + 1;

	kvp_pkg::kvp_res_t mem_q [kvp_pkg::QUEUE_DEPTH];
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic              pop;
	logic [AW-1:0]     tail_p1;

	assign res_valid = (count_q != '0);
	assign res_item  = mem_q[head_q];
	assign pop       = res_valid && !res_stall;
	assign tail_p1   = tail_q + AW'(1);
	// room for two results is required before an item is taken
	assign full      = (count_q > CW'(kvp_pkg::QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[tail_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem_q[tail_p1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + AW'(1);
			end
			tail_q  <= tail_q + AW'(push.num);
			count_q <= count_q + CW'(push.num) - CW'(pop);
		end
	end

endmodule

>>> rtl/kv_command_line_parser_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake             | payload
// cmd     | in        | cmd_valid / cmd_stall | cmd_item : in_byte, line_end
// res     | out       | res_valid / res_stall | res_item : part, out_byte, command,
//         |           |                       |   accepted, key_length, value_length
//
// One byte item per cycle while cmd_stall is low; each item is parsed combinationally
// into a four-entry result queue, and an item with line_end set writes its verdict
// there as well. Results leave one per cycle while res_stall is low.
// cmd_stall is high while the queue has fewer than two free entries.
// Reset returns the parser to the start of a line and empties the queue.

module kv_command_line_parser_top #(
	parameter int KEY_BYTES   = kvp_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BYTES = kvp_pkg::VALUE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  kvp_pkg::kvp_in_t  cmd_item,
	output logic              res_valid,
	input  logic              res_stall,
	output kvp_pkg::kvp_res_t res_item
);

	kvp_pkg::kvp_push_t push;
	logic               take;

	assign take = cmd_valid && !cmd_stall;

	kvp_parser #(
		.KEY_BYTES  (KEY_BYTES),
		.VALUE_BYTES(VALUE_BYTES)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (cmd_item),
		.push  (push)
	);

	kvp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (cmd_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

endmodule

>>> sim/kv_command_line_parser_top_tb.sv
`timescale 1ns / 1ps

module kv_command_line_parser_top_tb;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_BYTES = 900;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	kvp_pkg::kvp_in_t  cmd_item = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	kvp_pkg::kvp_res_t res_item;

	kv_command_line_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item (cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	// parser state mirror
	kvp_pkg::kvp_phase_t ph = kvp_pkg::PH_LEAD;
	kvp_pkg::kvp_cmd_t   kind = kvp_pkg::CMD_GET;
	logic [1:0]          chars = '0;
	logic [6:0]          key_n = '0;
	logic [8:0]          val_n = '0;
	logic                line_bad = 1'b0;

	kvp_pkg::kvp_res_t parsed_outputs[$];
	kvp_pkg::kvp_res_t want_res;
	logic [7:0]        line_bytes[$];
	int                errors = 0;
	int                cycles = 0;
	int                bytes_sent = 0;
	bit                calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == kvp_pkg::CH_SP || c == kvp_pkg::CH_TAB;
	endfunction

	function automatic void push_result(input kvp_pkg::kvp_part_t p, input logic [7:0] b,
			input kvp_pkg::kvp_cmd_t k, input logic acc, input logic [5:0] kl,
			input logic [7:0] vl);
		kvp_pkg::kvp_res_t r;
		r.part = p;
		r.out_byte = b;
		r.command = k;
		r.accepted = acc;
		r.key_length = kl;
		r.value_length = vl;
		parsed_outputs.push_back(r);
	endfunction

	function automatic void reject_line();
		line_bad = 1'b1;
		ph = kvp_pkg::PH_DISCARD;
	endfunction

	function automatic void take_letter(input logic [7:0] c, input logic [1:0] pos);
		if (pos == 2'd0) begin
			if (c == kvp_pkg::CH_G) kind = kvp_pkg::CMD_GET;
			else if (c == kvp_pkg::CH_S) kind = kvp_pkg::CMD_SET;
			else if (c == kvp_pkg::CH_D) kind = kvp_pkg::CMD_DEL;
			else begin
				reject_line();
				return;
			end
		end else if (pos == 2'd1) begin
			if (c != kvp_pkg::CH_E) begin
				reject_line();
				return;
			end
		end else if (c != ((kind == kvp_pkg::CMD_DEL) ? kvp_pkg::CH_L : kvp_pkg::CH_T)) begin
			reject_line();
			return;
		end
		chars = pos + 2'd1;
	endfunction

	function automatic void pass_byte(input kvp_pkg::kvp_part_t p, input logic [7:0] c);
		if (p == kvp_pkg::PART_KEY) begin
			if (int'(key_n) + 1 >= kvp_pkg::KEY_BYTES_DEF) begin
				reject_line();
				return;
			end
			key_n++;
		end else begin
			if (int'(val_n) + 1 >= kvp_pkg::VALUE_BYTES_DEF) begin
				reject_line();
				return;
			end
			val_n++;
		end
		push_result(p, c, kvp_pkg::CMD_GET, 1'b0, 6'd0, 8'd0);
	endfunction

	function automatic void parse_byte(input logic [7:0] c, input logic last);
		logic ok;
		if (!(last && c == kvp_pkg::CH_CR)) begin
			case (ph)
				kvp_pkg::PH_LEAD: begin
					if (!is_blank(c)) begin
						ph = kvp_pkg::PH_CMD;
						take_letter(c, 2'd0);
					end
				end
				kvp_pkg::PH_CMD: begin
					if (chars < 2'd3) take_letter(c, chars);
					else if (c == kvp_pkg::CH_SP) ph = kvp_pkg::PH_GAP;
					else reject_line();
				end
				kvp_pkg::PH_GAP: begin
					if (!is_blank(c)) begin
						ph = kvp_pkg::PH_KEY;
						pass_byte(kvp_pkg::PART_KEY, c);
					end
				end
				kvp_pkg::PH_KEY: begin
					if (c == kvp_pkg::CH_SP) ph = kvp_pkg::PH_TRAIL;
					else pass_byte(kvp_pkg::PART_KEY, c);
				end
				kvp_pkg::PH_TRAIL: begin
					if (!is_blank(c)) begin
						if (kind != kvp_pkg::CMD_SET) reject_line();
						else begin
							ph = kvp_pkg::PH_VALUE;
							pass_byte(kvp_pkg::PART_VALUE, c);
						end
					end
				end
				kvp_pkg::PH_VALUE: begin
					pass_byte(kvp_pkg::PART_VALUE, c);
				end
				default: ;
			endcase
		end
		if (last) begin
			ok = 1'b0;
			if (!line_bad) begin
				if (ph == kvp_pkg::PH_KEY || ph == kvp_pkg::PH_TRAIL)
					ok = (kind != kvp_pkg::CMD_SET);
				else if (ph == kvp_pkg::PH_VALUE)
					ok = (kind == kvp_pkg::CMD_SET);
			end
			if (ok)
				push_result(kvp_pkg::PART_VERDICT, 8'd0, kind, 1'b1, key_n[5:0],
					(kind == kvp_pkg::CMD_SET) ? val_n[7:0] : 8'd0);
			else
				push_result(kvp_pkg::PART_VERDICT, 8'd0, kvp_pkg::CMD_GET, 1'b0, 6'd0,
					8'd0);
			ph = kvp_pkg::PH_LEAD;
			kind = kvp_pkg::CMD_GET;
			chars = '0;
			key_n = '0;
			val_n = '0;
			line_bad = 1'b0;
		end
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (parsed_outputs.size() == 0) begin
				$display("%0t unexpected item: expected none, actual %h", $time, res_item);
				errors++;
			end else begin
				want_res = parsed_outputs.pop_front();
				check_field("part", want_res.part, res_item.part);
				check_field("out_byte", want_res.out_byte, res_item.out_byte);
				check_field("command", want_res.command, res_item.command);
				check_field("accepted", want_res.accepted, res_item.accepted);
				check_field("key_length", want_res.key_length, res_item.key_length);
				check_field("value_length", want_res.value_length, res_item.value_length);
			end
		end
		res_stall <= !calm && ($urandom_range(99) < 18);
	end

	task automatic send_byte(input logic [7:0] c, input logic last);
		if (!calm && $urandom_range(99) < 22) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_item <= '{in_byte: c, line_end: last};
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		bytes_sent++;
		parse_byte(c, last);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_bytes.size(); i++)
			send_byte(line_bytes[i], i == line_bytes.size() - 1);
		line_bytes.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endtask

	task automatic add_blanks(input int unsigned n);
		repeat (n) line_bytes.push_back($urandom_range(1) ? kvp_pkg::CH_SP : kvp_pkg::CH_TAB);
	endtask

	task automatic add_chars(input int unsigned n, input bit no_space);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(255));
			if (no_space && b == kvp_pkg::CH_SP) b = 8'h5F;
			line_bytes.push_back(b);
		end
	endtask

	task automatic test_commands();
		add_text("GET a");
		line_bytes.push_back(kvp_pkg::CH_CR);
		send_line();
		add_text("SET key val ue");
		send_line();
		line_bytes.push_back(kvp_pkg::CH_TAB);
		add_text("DEL  k");
		line_bytes.push_back(8'h00);
		line_bytes.push_back(8'hFF);
		line_bytes.push_back(kvp_pkg::CH_SP);
		line_bytes.push_back(kvp_pkg::CH_TAB);
		line_bytes.push_back(kvp_pkg::CH_CR);
		send_line();
	endtask

	task automatic test_malformed();
		add_text("GEX k");
		send_line();
		add_text("SET");
		line_bytes.push_back(kvp_pkg::CH_TAB);
		add_text("k v");
		send_line();
		add_text("GETS k");
		send_line();
		add_text("GE");
		send_line();
		add_text("DEL ");
		send_line();
		add_text("SET k");
		send_line();
		add_text("SET k  ");
		line_bytes.push_back(kvp_pkg::CH_CR);
		send_line();
		add_text("GET k x");
		send_line();
		line_bytes.push_back(kvp_pkg::CH_CR);
		send_line();
		add_text(" ");
		line_bytes.push_back(kvp_pkg::CH_TAB);
		send_line();
		// carriage return inside the key is a plain key byte
		add_text("GET a");
		line_bytes.push_back(kvp_pkg::CH_CR);
		add_text("b");
		send_line();
	endtask

	task automatic test_length_limits();
		add_text("GET ");
		repeat (kvp_pkg::KEY_BYTES_DEF - 1) line_bytes.push_back(8'h6B);
		send_line();
		add_text("DEL ");
		repeat (kvp_pkg::KEY_BYTES_DEF) line_bytes.push_back(8'h6B);
		send_line();
		add_text("SET k ");
		add_chars(kvp_pkg::VALUE_BYTES_DEF - 1, 1'b0);
		line_bytes[6] = 8'h76;
		send_line();
		add_text("SET k ");
		add_chars(kvp_pkg::VALUE_BYTES_DEF, 1'b0);
		line_bytes[6] = 8'h76;
		send_line();
	endtask

	task automatic build_random_line();
		int unsigned roll;
		int unsigned klen;
		int unsigned vlen;
		kvp_pkg::kvp_cmd_t k;
		roll = $urandom_range(99);
		if (roll < 12) begin
			add_chars($urandom_range(8, 1), 1'b0);
			return;
		end
		add_blanks($urandom_range(2));
		k = kvp_pkg::kvp_cmd_t'($urandom_range(2));
		case (k)
			kvp_pkg::CMD_GET: add_text("GET");
			kvp_pkg::CMD_SET: add_text("SET");
			default: add_text("DEL");
		endcase
		if (roll < 20)
			line_bytes[line_bytes.size() - 1 - $urandom_range(2)] = 8'($urandom_range(255));
		if (roll >= 20 && roll < 24) add_chars(1, 1'b0);
		else line_bytes.push_back(kvp_pkg::CH_SP);
		add_blanks($urandom_range(2));
		if (roll >= 24 && roll < 28) begin
			add_blanks($urandom_range(1));
		end else begin
			klen = ($urandom_range(49) == 0) ? $urandom_range(70, 55) : $urandom_range(8, 1);
			add_chars(klen, 1'b1);
			if (k == kvp_pkg::CMD_SET && roll >= 34) begin
				line_bytes.push_back(kvp_pkg::CH_SP);
				add_blanks($urandom_range(2));
				vlen = ($urandom_range(49) == 0) ? $urandom_range(260, 250) :
					$urandom_range(12, 1);
				add_chars(vlen, 1'b0);
			end else if (roll < 34) begin
				if ($urandom_range(1)) begin
					line_bytes.push_back(kvp_pkg::CH_SP);
					add_blanks($urandom_range(2));
					if (k != kvp_pkg::CMD_SET) add_chars($urandom_range(3, 1), 1'b1);
				end
			end else if ($urandom_range(1)) begin
				line_bytes.push_back(kvp_pkg::CH_SP);
				add_blanks($urandom_range(3));
			end
		end
		if ($urandom_range(1)) line_bytes.push_back(kvp_pkg::CH_CR);
	endtask

	task automatic test_random_lines();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			calm = (bytes_sent - start >= 300) && (bytes_sent - start < 550);
			build_random_line();
			send_line();
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_malformed();
		test_length_limits();
		test_random_lines();
		cmd_valid <= 1'b0;
		while (parsed_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
